// ===== hdl/dirty_region_flush_planner_assert.svh =====
// assertion macros used by the planner control module
`ifndef DIRTY_REGION_FLUSH_PLANNER_ASSERT_SVH
`define DIRTY_REGION_FLUSH_PLANNER_ASSERT_SVH

// same-cycle implication
`define DRFP_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("drfp assertion failed");

// next-cycle implication
`define DRFP_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("drfp assertion failed");

`endif

// ===== hdl/drfp_pkg.sv =====
package drfp_pkg;

    localparam int COORD_W  = 13;
    localparam int XY_W     = 12;
    localparam int PITCH_W  = 16;
    localparam int MARGIN_W = 12;
    localparam int BYTE_W   = 32;
    localparam int PROD_W   = PITCH_W + COORD_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] FUNC_POINT = 2'd0;
    localparam logic [1:0] FUNC_RECT  = 2'd1;
    localparam logic [1:0] FUNC_FLUSH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_MARGIN   = 2'd3;

    localparam logic [COORD_W-1:0]  SCREEN_WIDTH_RST  = 13'd640;
    localparam logic [COORD_W-1:0]  SCREEN_HEIGHT_RST = 13'd480;
    localparam logic [PITCH_W-1:0]  LINE_PITCH_RST    = 16'd2560;
    localparam logic [MARGIN_W-1:0] WIDE_MARGIN_RST   = 12'd600;

    localparam logic [COORD_W-1:0] MAX_SPLIT_ROWS = 13'd36;

    typedef struct packed {
        logic grow;
        logic clamp;
        logic mul_start;
        logic base_step;
        logic len_step;
        logic load_comb;
        logic load_row;
        logic clear;
    } drfp_cmd_t;

    typedef struct packed {
        logic dirty;
        logic off_screen;
        logic use_comb;
        logic row_last;
    } drfp_sts_t;

endpackage

// ===== hdl/drfp_in_if.sv =====
interface drfp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [drfp_pkg::XY_W-1:0] pos_x;
    logic [drfp_pkg::XY_W-1:0] pos_y;
    logic [drfp_pkg::XY_W-1:0] rect_w;
    logic [drfp_pkg::XY_W-1:0] rect_h;

    modport source (output valid, func, pos_x, pos_y, rect_w, rect_h, input ready);
    modport sink   (input valid, func, pos_x, pos_y, rect_w, rect_h, output ready);
endinterface

// ===== hdl/drfp_out_if.sv =====
interface drfp_out_if;
    logic valid;
    logic ready;
    logic [drfp_pkg::BYTE_W-1:0] byte_offset;
    logic [drfp_pkg::BYTE_W-1:0] byte_length;
    logic is_combined;
    logic last;

    modport source (output valid, byte_offset, byte_length, is_combined, last, input ready);
    modport sink   (input valid, byte_offset, byte_length, is_combined, last, output ready);
endinterface

// ===== hdl/drfp_datapath.sv =====
module drfp_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [drfp_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [drfp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [1:0]                        func,
    input  logic [drfp_pkg::XY_W-1:0]         pos_x,
    input  logic [drfp_pkg::XY_W-1:0]         pos_y,
    input  logic [drfp_pkg::XY_W-1:0]         rect_w,
    input  logic [drfp_pkg::XY_W-1:0]         rect_h,
    input  drfp_pkg::drfp_cmd_t               cmd,
    output drfp_pkg::drfp_sts_t               sts,
    output logic [drfp_pkg::BYTE_W-1:0]       byte_offset,
    output logic [drfp_pkg::BYTE_W-1:0]       byte_length,
    output logic                              is_combined,
    output logic                              last
);

    localparam int CW = drfp_pkg::COORD_W;
    localparam int BW = drfp_pkg::BYTE_W;

    logic [CW-1:0]                    sw_reg;
    logic [CW-1:0]                    sh_reg;
    logic [drfp_pkg::PITCH_W-1:0]     pitch_reg;
    logic [drfp_pkg::MARGIN_W-1:0]    margin_reg;

    logic          dirty_reg;
    logic [CW-1:0] min_col_reg;
    logic [CW-1:0] min_row_reg;
    logic [CW-1:0] max_col_reg;
    logic [CW-1:0] max_row_reg;
    logic [CW-1:0] row_cursor_reg;

    logic [drfp_pkg::PROD_W-1:0] prod_reg;
    logic [BW-1:0]               off_reg;
    logic [BW-1:0]               len_reg;
    logic [BW-1:0]               out_off_reg;
    logic [BW-1:0]               out_len_reg;
    logic                        out_comb_reg;
    logic                        out_last_reg;

    logic [CW-1:0] w_eff;
    logic [CW-1:0] h_eff;
    logic [CW-1:0] lx;
    logic [CW-1:0] ly;
    logic [CW-1:0] hx;
    logic [CW-1:0] hy;
    logic [CW-1:0] col_span;
    logic [CW-1:0] row_span;
    logic [CW-1:0] margin_ext;
    logic [CW:0]   col_span_p1;
    logic [CW+2:0] row_len;
    logic [CW-1:0] mul_b;
    logic [drfp_pkg::PROD_W-1:0] prod_next;
    logic          wide;

    always_comb
    begin
        w_eff      = (sw_reg == '0) ? CW'(1) : sw_reg;
        h_eff      = (sh_reg == '0) ? CW'(1) : sh_reg;
        lx         = {1'b0, pos_x};
        ly         = {1'b0, pos_y};
        hx         = lx + ((func == drfp_pkg::FUNC_RECT) ? {1'b0, rect_w} : '0);
        hy         = ly + ((func == drfp_pkg::FUNC_RECT) ? {1'b0, rect_h} : '0);
        col_span   = max_col_reg - min_col_reg;
        row_span   = max_row_reg - min_row_reg;
        margin_ext = {1'b0, margin_reg};
        col_span_p1 = {1'b0, col_span} + (CW+1)'(1);
        row_len    = {col_span_p1, 2'b00};
        wide       = (margin_ext <= w_eff) && (col_span > (w_eff - margin_ext));
        mul_b      = cmd.mul_start ? min_row_reg : row_span;
        prod_next  = drfp_pkg::PROD_W'(pitch_reg) * drfp_pkg::PROD_W'(mul_b);

        sts.dirty      = dirty_reg;
        sts.off_screen = (min_col_reg > max_col_reg) || (min_row_reg > max_row_reg);
        sts.use_comb   = wide || (row_span >= drfp_pkg::MAX_SPLIT_ROWS);
        sts.row_last   = (row_cursor_reg == max_row_reg);
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg     <= drfp_pkg::SCREEN_WIDTH_RST;
            sh_reg     <= drfp_pkg::SCREEN_HEIGHT_RST;
            pitch_reg  <= drfp_pkg::LINE_PITCH_RST;
            margin_reg <= drfp_pkg::WIDE_MARGIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                drfp_pkg::CFG_SCREEN_WIDTH:  sw_reg     <= cfg_data[CW-1:0];
                drfp_pkg::CFG_SCREEN_HEIGHT: sh_reg     <= cfg_data[CW-1:0];
                drfp_pkg::CFG_LINE_PITCH:    pitch_reg  <= cfg_data;
                drfp_pkg::CFG_WIDE_MARGIN:   margin_reg <= cfg_data[drfp_pkg::MARGIN_W-1:0];
                default:                     sw_reg     <= sw_reg;
            endcase
        end
    end

    // bounding box
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dirty_reg      <= 1'b0;
            min_col_reg    <= '0;
            min_row_reg    <= '0;
            max_col_reg    <= '0;
            max_row_reg    <= '0;
            row_cursor_reg <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                dirty_reg   <= 1'b0;
                min_col_reg <= '0;
                min_row_reg <= '0;
                max_col_reg <= '0;
                max_row_reg <= '0;
            end
            else if (cmd.grow)
            begin
                dirty_reg <= 1'b1;
                if (!dirty_reg)
                begin
                    min_col_reg <= lx;
                    min_row_reg <= ly;
                    max_col_reg <= hx;
                    max_row_reg <= hy;
                end
                else
                begin
                    if (lx < min_col_reg) min_col_reg <= lx;
                    if (ly < min_row_reg) min_row_reg <= ly;
                    if (hx > max_col_reg) max_col_reg <= hx;
                    if (hy > max_row_reg) max_row_reg <= hy;
                end
            end
            else if (cmd.clamp)
            begin
                if (max_col_reg >= w_eff) max_col_reg <= w_eff - CW'(1);
                if (max_row_reg >= h_eff) max_row_reg <= h_eff - CW'(1);
            end

            priority if (cmd.clear)
                row_cursor_reg <= '0;
            else if (cmd.base_step)
                row_cursor_reg <= min_row_reg;
            else if (cmd.load_row)
                row_cursor_reg <= row_cursor_reg + CW'(1);
        end
    end

    // address arithmetic and output register
    always_ff @(posedge clk)
    begin
        if (cmd.mul_start || cmd.base_step)
            prod_reg <= prod_next;

        if (cmd.base_step)
            off_reg <= BW'(prod_reg) + BW'({min_col_reg, 2'b00});
        else if (cmd.load_row)
            off_reg <= off_reg + BW'(pitch_reg);

        if (cmd.len_step)
            len_reg <= BW'(prod_reg) + BW'(row_len);

        if (cmd.load_comb)
        begin
            out_off_reg  <= off_reg;
            out_len_reg  <= len_reg;
            out_comb_reg <= 1'b1;
            out_last_reg <= 1'b1;
        end
        else if (cmd.load_row)
        begin
            out_off_reg  <= off_reg;
            out_len_reg  <= BW'(row_len);
            out_comb_reg <= 1'b0;
            out_last_reg <= sts.row_last;
        end
    end

    assign byte_offset = out_off_reg;
    assign byte_length = out_len_reg;
    assign is_combined = out_comb_reg;
    assign last        = out_last_reg;

endmodule

// ===== hdl/drfp_ctrl.sv =====
module drfp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           func,
    input  logic                 out_ready,
    output logic                 out_valid,
    input  drfp_pkg::drfp_sts_t  sts,
    output drfp_pkg::drfp_cmd_t  cmd
);

    `include "dirty_region_flush_planner_assert.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLAMP,
        S_CHECK,
        S_BASE,
        S_LEN,
        S_EMIT_COMB,
        S_ROWS
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   comb_reg;
    logic   comb_next;
    logic   in_fire;
    logic   flush_go;
    logic   slot_free;

    always_comb
    begin
        in_ready  = (state_reg == S_IDLE);
        in_fire   = in_valid && in_ready;
        flush_go  = in_fire && (func == drfp_pkg::FUNC_FLUSH) && sts.dirty;
        slot_free = !out_valid_reg || out_ready;

        cmd.grow      = in_fire && ((func == drfp_pkg::FUNC_POINT) ||
                                    (func == drfp_pkg::FUNC_RECT));
        cmd.clamp     = (state_reg == S_CLAMP);
        cmd.mul_start = (state_reg == S_CHECK) && !sts.off_screen;
        cmd.base_step = (state_reg == S_BASE);
        cmd.len_step  = (state_reg == S_LEN);
        cmd.load_comb = (state_reg == S_EMIT_COMB) && slot_free;
        cmd.load_row  = (state_reg == S_ROWS) && slot_free;
        cmd.clear     = ((state_reg == S_CHECK) && sts.off_screen) || cmd.load_comb ||
                        (cmd.load_row && sts.row_last);

        state_next = state_reg;
        comb_next  = comb_reg;
        unique case (state_reg)
            S_IDLE:
                if (flush_go)
                    state_next = S_CLAMP;
            S_CLAMP:
                state_next = S_CHECK;
            S_CHECK:
            begin
                comb_next  = sts.use_comb;
                state_next = sts.off_screen ? S_IDLE : S_BASE;
            end
            S_BASE:
                state_next = comb_reg ? S_LEN : S_ROWS;
            S_LEN:
                state_next = S_EMIT_COMB;
            S_EMIT_COMB:
                if (cmd.load_comb)
                    state_next = S_IDLE;
            S_ROWS:
                if (cmd.load_row && sts.row_last)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase

        priority if (cmd.load_comb || cmd.load_row)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            comb_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            comb_reg      <= comb_next;
        end
    end

    assign out_valid = out_valid_reg;

    `DRFP_ASSERT_IMPL(a_load_into_free_slot, clk, rst_n, (cmd.load_comb || cmd.load_row), (!out_valid_reg || out_ready))
    `DRFP_ASSERT_NEXT(a_flush_starts_clamp, clk, rst_n, flush_go, (state_reg == S_CLAMP))
    `DRFP_ASSERT_NEXT(a_last_row_ends_flush, clk, rst_n, (cmd.load_row && sts.row_last), (state_reg == S_IDLE))
    `DRFP_ASSERT_IMPL(a_single_command, clk, rst_n, 1'b1, $onehot0({cmd.grow, cmd.clamp, cmd.mul_start, cmd.base_step, cmd.len_step, cmd.load_comb, cmd.load_row}))

endmodule

// ===== hdl/dirty_region_flush_planner.sv =====
// dirty rectangle flush planner
// in_ch carries marks and flushes (func: mark point, mark rectangle, flush);
// out_ch carries the planned copy ranges (byte_offset, byte_length,
// is_combined, last). a transfer happens when valid and ready are both high.
// the cfg port writes screen_width, screen_height, line_pitch and wide_margin
// by index; write only while no flush is being planned.
// a mark grows the box on acceptance and in_ch.ready stays high in idle, so
// marks can follow back to back. a flush holds in_ch.ready low until its last
// range is loaded into the output register: clamp, check and base, then a
// length step and the combined range, or one row range per cycle while the
// output register is free, set by the single output register and the row
// counter that steps the start address by the line pitch. a flush of an empty
// box produces nothing. when out_ch.ready is low the output register holds
// its range and planning waits; in_ch takes marks again once the last range
// is loaded, even while it waits. reset empties the box, drops any pending
// range and restores the register defaults 640, 480, 2560 and 600.
module dirty_region_flush_planner (
    input  logic                              clk,
    input  logic                              rst_n,
    drfp_in_if.sink                           in_ch,
    drfp_out_if.source                        out_ch,
    input  logic                              cfg_we,
    input  logic [drfp_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [drfp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    drfp_pkg::drfp_cmd_t cmd;
    drfp_pkg::drfp_sts_t sts;

    drfp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .func      (in_ch.func),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    drfp_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_idx),
        .cfg_data    (cfg_data),
        .func        (in_ch.func),
        .pos_x       (in_ch.pos_x),
        .pos_y       (in_ch.pos_y),
        .rect_w      (in_ch.rect_w),
        .rect_h      (in_ch.rect_h),
        .cmd         (cmd),
        .sts         (sts),
        .byte_offset (out_ch.byte_offset),
        .byte_length (out_ch.byte_length),
        .is_combined (out_ch.is_combined),
        .last        (out_ch.last)
    );

endmodule
